// ----- hw/rtl/ebbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder bang-bang positioner package
// Shared word types, register indexes, reset values and duty codes.
// ----------------------------------------------------------------------------
package ebbp_pkg;

   localparam int POS_WIDTH_DEFAULT = 16;

   localparam int FIELD_POS_WIDTH  = 16;
   localparam int FIELD_DUTY_WIDTH = 9;
   localparam int DEADBAND_WIDTH   = 8;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_MIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_MAX = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADBAND  = 2'd2;

   localparam int COUNT_MIN_RESET = 20;
   localparam int COUNT_MAX_RESET = 181;
   localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RESET = 8'd1;

   localparam logic [FIELD_DUTY_WIDTH-1:0] DUTY_EXTEND  = 9'd0;
   localparam logic [FIELD_DUTY_WIDTH-1:0] DUTY_STOP    = 9'd200;
   localparam logic [FIELD_DUTY_WIDTH-1:0] DUTY_RETRACT = 9'd400;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic                       func;
      logic                       dir_level;
      logic [FIELD_POS_WIDTH-1:0] target;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_DUTY_WIDTH-1:0] duty;
      logic [FIELD_POS_WIDTH-1:0]  reported_position;
      logic [FIELD_POS_WIDTH-1:0]  counter_value;
      logic                        drive_changed;
   } rsp_word_type;

   typedef struct packed {
      logic                       wr_en;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  wdata;
   } csr_write_type;

endpackage

// ----- hw/rtl/encoder_bang_bang_positioner.sv -----
// ----------------------------------------------------------------------------
// Encoder bang-bang positioner
// One actuator channel: clamped encoder counter and deadband bang-bang drive.
//
//   Channel   Ports                          Direction   Word
//   request   req_valid/req_ready/req_word   in          func, dir_level, target
//   response  rsp_valid/rsp_ready/rsp_word   out         duty, positions, changed
//   control   csr_wr_en/csr_index/csr_wdata  in          limits and deadband
//
// Each word is held in the input register, then evaluated and written to the
// output register when that register is free.
// Throughput is one word per cycle while no response stall holds the flow.
// Reset is synchronous and clears both handshake stages and the controller state.
// A stalled response holds the input register; one more word can wait there.
// ----------------------------------------------------------------------------
module encoder_bang_bang_positioner #(
   parameter int PosWidth = ebbp_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  ebbp_pkg::req_word_type                   req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output ebbp_pkg::rsp_word_type                   rsp_word,
   input  logic                                     csr_wr_en,
   input  logic [ebbp_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ebbp_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   logic                    item_valid;
   ebbp_pkg::req_word_type  item_word;
   ebbp_pkg::rsp_word_type  result;
   ebbp_pkg::csr_write_type csr;
   logic                    out_free;
   logic                    advance;

   assign advance   = item_valid && out_free;
   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   ebbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .advance    (advance),
      .item_valid (item_valid),
      .item_word  (item_word)
   );

   ebbp_core #(
      .PosWidth (PosWidth)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .advance   (advance),
      .item_word (item_word),
      .result    (result)
   );

   ebbp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- hw/rtl/ebbp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input stage
// Holds one accepted request word until the core consumes it.
// ----------------------------------------------------------------------------
module ebbp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ebbp_pkg::req_word_type req_word,
   input  logic                   advance,
   output logic                   item_valid,
   output ebbp_pkg::req_word_type item_word
);

   logic                   valid_ff;
   logic                   valid_in;
   ebbp_pkg::req_word_type word_ff;
   logic                   take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign item_valid = valid_ff;
   assign item_word  = word_ff;

endmodule

// ----- hw/rtl/ebbp_core.sv -----
// ----------------------------------------------------------------------------
// Positioner core
// Configuration registers, controller state, and the edge and tick update.
// ----------------------------------------------------------------------------
module ebbp_core #(
   parameter int PosWidth = ebbp_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ebbp_pkg::csr_write_type csr,
   input  logic                    advance,
   input  ebbp_pkg::req_word_type  item_word,
   output ebbp_pkg::rsp_word_type  result
);

   localparam int SW = PosWidth + 2;
   localparam int FW = ebbp_pkg::FIELD_POS_WIDTH;

   logic [PosWidth-1:0]                     count_min_ff;
   logic [PosWidth-1:0]                     count_max_ff;
   logic [ebbp_pkg::DEADBAND_WIDTH-1:0]     deadband_ff;
   logic [PosWidth+FW-1:0]                  wdata_ext;

   logic [PosWidth-1:0]                     position_ff;
   logic [PosWidth-1:0]                     position_in;
   logic                                    forward_ff;
   logic                                    forward_in;
   logic                                    reverse_ff;
   logic                                    reverse_in;
   logic                                    stopped_ff;
   logic                                    stopped_in;
   logic [ebbp_pkg::FIELD_DUTY_WIDTH-1:0]   duty_ff;
   logic [ebbp_pkg::FIELD_DUTY_WIDTH-1:0]   duty_in;
   logic [PosWidth-1:0]                     reported_ff;
   logic [PosWidth-1:0]                     reported_in;
   logic                                    changed;

   logic [PosWidth+FW-1:0]                  target_ext;
   logic [PosWidth-1:0]                     target_pos;
   logic signed [SW-1:0]                    t_s;
   logic signed [SW-1:0]                    db_s;
   logic signed [SW-1:0]                    lo_s;
   logic signed [SW-1:0]                    hi_s;
   logic signed [SW-1:0]                    pos_s;
   logic signed [SW-1:0]                    cnt_s;
   logic signed [SW-1:0]                    min_s;
   logic signed [SW-1:0]                    max_s;
   logic [PosWidth+FW-1:0]                  cnt_ext;
   logic [PosWidth+FW-1:0]                  rep_ext;

   assign wdata_ext = {PosWidth'(0), csr.wdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_min_ff <= PosWidth'(ebbp_pkg::COUNT_MIN_RESET);
         count_max_ff <= PosWidth'(ebbp_pkg::COUNT_MAX_RESET);
         deadband_ff  <= ebbp_pkg::DEADBAND_RESET;
      end else if (csr.wr_en) begin
         case (csr.index)
            ebbp_pkg::CSR_COUNT_MIN: begin
               count_min_ff <= wdata_ext[PosWidth-1:0];
            end
            ebbp_pkg::CSR_COUNT_MAX: begin
               count_max_ff <= wdata_ext[PosWidth-1:0];
            end
            ebbp_pkg::CSR_DEADBAND: begin
               deadband_ff <= csr.wdata[ebbp_pkg::DEADBAND_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign target_ext = {PosWidth'(0), item_word.target};
   assign target_pos = target_ext[PosWidth-1:0];
   assign t_s        = signed'({2'b00, target_pos});
   assign db_s       = signed'({(SW - ebbp_pkg::DEADBAND_WIDTH)'(0), deadband_ff});
   assign lo_s       = t_s - db_s;
   assign hi_s       = t_s + db_s;
   assign min_s      = signed'({2'b00, count_min_ff});
   assign max_s      = signed'({2'b00, count_max_ff});

   always_comb begin
      position_in = position_ff;
      forward_in  = forward_ff;
      reverse_in  = reverse_ff;
      stopped_in  = stopped_ff;
      duty_in     = duty_ff;
      reported_in = reported_ff;
      changed     = 1'b0;
      pos_s       = signed'({2'b00, position_ff});
      cnt_s       = pos_s;
      if (item_word.func == ebbp_pkg::FUNC_EDGE) begin
         cnt_s = item_word.dir_level ? pos_s + SW'(1) : pos_s - SW'(1);
         if (cnt_s <= min_s) begin
            cnt_s = min_s;
         end
         if (cnt_s >= max_s) begin
            cnt_s = max_s;
         end
         position_in = cnt_s[PosWidth-1:0];
      end else begin
         if (pos_s < lo_s && !forward_in) begin
            duty_in    = ebbp_pkg::DUTY_EXTEND;
            forward_in = 1'b1;
            stopped_in = 1'b0;
            changed    = 1'b1;
         end
         if (pos_s > hi_s && !reverse_in) begin
            duty_in    = ebbp_pkg::DUTY_RETRACT;
            reverse_in = 1'b1;
            stopped_in = 1'b0;
            changed    = 1'b1;
         end
         if (pos_s >= lo_s && !stopped_in && forward_in) begin
            duty_in    = ebbp_pkg::DUTY_STOP;
            pos_s      = t_s;
            stopped_in = 1'b1;
            forward_in = 1'b0;
            reverse_in = 1'b0;
            changed    = 1'b1;
         end
         if (pos_s <= hi_s && !stopped_in && reverse_in) begin
            duty_in    = ebbp_pkg::DUTY_STOP;
            pos_s      = t_s;
            stopped_in = 1'b1;
            forward_in = 1'b0;
            reverse_in = 1'b0;
            changed    = 1'b1;
         end
         reported_in = pos_s[PosWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= PosWidth'(ebbp_pkg::COUNT_MIN_RESET);
         forward_ff  <= 1'b0;
         reverse_ff  <= 1'b0;
         stopped_ff  <= 1'b0;
         duty_ff     <= ebbp_pkg::DUTY_STOP;
         reported_ff <= '0;
      end else if (advance) begin
         position_ff <= position_in;
         forward_ff  <= forward_in;
         reverse_ff  <= reverse_in;
         stopped_ff  <= stopped_in;
         duty_ff     <= duty_in;
         reported_ff <= reported_in;
      end
   end

   assign cnt_ext = {FW'(0), position_in};
   assign rep_ext = {FW'(0), reported_in};

   assign result.duty              = duty_in;
   assign result.reported_position = rep_ext[FW-1:0];
   assign result.counter_value     = cnt_ext[FW-1:0];
   assign result.drive_changed     = changed;

endmodule

// ----- hw/rtl/ebbp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a response word until the consumer takes it.
// ----------------------------------------------------------------------------
module ebbp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ebbp_pkg::rsp_word_type result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ebbp_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff;
   logic                   valid_in;
   ebbp_pkg::rsp_word_type word_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder bang-bang positioner testbench
// Sends encoder edges and control ticks with random gaps and response stalls.
// It checks the first directed response words against fixed expected words and
// every other one against a local model of the counter clamp and the deadband
// rules, and it runs through several limit and deadband settings.
// ----------------------------------------------------------------------------
module testbench;
   import ebbp_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 115;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      bit                         is_setting;
      logic [CSR_INDEX_WIDTH-1:0] csr_idx;
      logic [CSR_DATA_WIDTH-1:0]  csr_data;
      req_word_type               word;
      bit                         typed;
      rsp_word_type               want;
   } stim_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_word_type               req_word;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_word_type               rsp_word;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   logic [FIELD_POS_WIDTH-1:0]  lim_min;
   logic [FIELD_POS_WIDTH-1:0]  lim_max;
   logic [DEADBAND_WIDTH-1:0]   band;
   logic [FIELD_POS_WIDTH-1:0]  pos_count;
   bit                          fwd;
   bit                          rev;
   bit                          stopped;
   logic [FIELD_DUTY_WIDTH-1:0] duty_reg;
   logic [FIELD_POS_WIDTH-1:0]  rep_pos;

   rsp_word_type awaited_reports[$];
   stim_row_type directed_rows[$];

   int error_count;
   int cycle_count;
   int edge_count;
   int tick_count;
   int change_count;
   int setting_count;

   encoder_bang_bang_positioner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_positioner();
      lim_min   = FIELD_POS_WIDTH'(COUNT_MIN_RESET);
      lim_max   = FIELD_POS_WIDTH'(COUNT_MAX_RESET);
      band      = DEADBAND_RESET;
      pos_count = FIELD_POS_WIDTH'(COUNT_MIN_RESET);
      fwd       = 1'b0;
      rev       = 1'b0;
      stopped   = 1'b0;
      duty_reg  = DUTY_STOP;
      rep_pos   = '0;
   endfunction

   function automatic void apply_setting(logic [CSR_INDEX_WIDTH-1:0] idx,
                                         logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_COUNT_MIN: lim_min = data;
         CSR_COUNT_MAX: lim_max = data;
         CSR_DEADBAND: band = data[DEADBAND_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_word_type position_step(req_word_type w);
      int           c;
      int           lo;
      int           hi;
      int           tgt;
      int           db;
      int           pos;
      bit           changed;
      rsp_word_type r;
      changed = 1'b0;
      if (w.func == FUNC_EDGE) begin
         c  = pos_count;
         lo = lim_min;
         hi = lim_max;
         c  = w.dir_level ? c + 1 : c - 1;
         if (c <= lo) c = lo;
         if (c >= hi) c = hi;
         pos_count = c[FIELD_POS_WIDTH-1:0];
      end else begin
         tgt = w.target;
         db  = band;
         lo  = tgt - db;
         hi  = tgt + db;
         pos = pos_count;
         if (pos < lo && !fwd) begin
            duty_reg = DUTY_EXTEND;
            fwd      = 1'b1;
            stopped  = 1'b0;
            changed  = 1'b1;
         end
         if (pos > hi && !rev) begin
            duty_reg = DUTY_RETRACT;
            rev      = 1'b1;
            stopped  = 1'b0;
            changed  = 1'b1;
         end
         if (pos >= lo && !stopped && fwd) begin
            duty_reg = DUTY_STOP;
            pos      = tgt;
            stopped  = 1'b1;
            fwd      = 1'b0;
            rev      = 1'b0;
            changed  = 1'b1;
         end
         if (pos <= hi && !stopped && rev) begin
            duty_reg = DUTY_STOP;
            pos      = tgt;
            stopped  = 1'b1;
            fwd      = 1'b0;
            rev      = 1'b0;
            changed  = 1'b1;
         end
         rep_pos = pos[FIELD_POS_WIDTH-1:0];
      end
      r.duty              = duty_reg;
      r.reported_position = rep_pos;
      r.counter_value     = pos_count;
      r.drive_changed     = changed;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type edge_word(bit up);
      req_word_type w;
      w.func      = FUNC_EDGE;
      w.dir_level = up;
      w.target    = '0;
      return w;
   endfunction

   function automatic req_word_type tick_word(logic [FIELD_POS_WIDTH-1:0] tgt);
      req_word_type w;
      w.func      = FUNC_TICK;
      w.dir_level = 1'b0;
      w.target    = tgt;
      return w;
   endfunction

   function automatic rsp_word_type report(logic [FIELD_DUTY_WIDTH-1:0] duty,
                                           logic [FIELD_POS_WIDTH-1:0] rep,
                                           logic [FIELD_POS_WIDTH-1:0] cnt,
                                           bit ch);
      rsp_word_type r;
      r.duty              = duty;
      r.reported_position = rep;
      r.counter_value     = cnt;
      r.drive_changed     = ch;
      return r;
   endfunction

   function automatic void add_checked(req_word_type w, rsp_word_type want);
      stim_row_type row;
      row.is_setting = 1'b0;
      row.csr_idx    = '0;
      row.csr_data   = '0;
      row.word       = w;
      row.typed      = 1'b1;
      row.want       = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_word(req_word_type w);
      add_checked(w, '0);
      directed_rows[directed_rows.size() - 1].typed = 1'b0;
   endfunction

   function automatic void add_setting(logic [CSR_INDEX_WIDTH-1:0] idx,
                                       logic [CSR_DATA_WIDTH-1:0] data);
      stim_row_type row;
      row.is_setting = 1'b1;
      row.csr_idx    = idx;
      row.csr_data   = data;
      row.word       = '0;
      row.typed      = 1'b0;
      row.want       = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic send_word(req_word_type w, bit typed, rsp_word_type want);
      rsp_word_type got;
      req_word  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = position_step(w);
      awaited_reports.push_back(typed ? want : got);
      if (w.func == FUNC_EDGE) edge_count++;
      else tick_count++;
      if (got.drive_changed) change_count++;
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_replies();
      req_valid = 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(logic [CSR_INDEX_WIDTH-1:0] idx,
                                logic [CSR_DATA_WIDTH-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      apply_setting(idx, data);
      setting_count++;
   endtask

   task automatic write_limits(logic [FIELD_POS_WIDTH-1:0] lo_lim,
                               logic [FIELD_POS_WIDTH-1:0] hi_lim,
                               logic [DEADBAND_WIDTH-1:0] db);
      write_setting(CSR_COUNT_MIN, lo_lim);
      write_setting(CSR_COUNT_MAX, hi_lim);
      write_setting(CSR_DEADBAND, {8'($urandom_range(0, 255)), db});
      if ($urandom_range(0, 2) == 0) write_setting(CSR_SPARE, CSR_DATA_WIDTH'($urandom));
   endtask

   initial begin : reply_stalls
      int span;
      rsp_ready = 1'b0;
      forever begin
         if ($urandom_range(0, 9) == 0) span = $urandom_range(100, 300);
         else span = $urandom_range(1, 12);
         rsp_ready = 1'b1;
         repeat (span) @(negedge clock);
         rsp_ready = 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   end

   always @(posedge clock) begin : reply_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("Response word arrived with none outstanding: %h", rsp_word);
            error_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_word.duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_word.duty);
               error_count++;
            end
            if (rsp_word.reported_position !== want.reported_position) begin
               $error("reported_position: expected %0d, got %0d",
                      want.reported_position, rsp_word.reported_position);
               error_count++;
            end
            if (rsp_word.counter_value !== want.counter_value) begin
               $error("counter_value: expected %0d, got %0d",
                      want.counter_value, rsp_word.counter_value);
               error_count++;
            end
            if (rsp_word.drive_changed !== want.drive_changed) begin
               $error("drive_changed: expected %0d, got %0d",
                      want.drive_changed, rsp_word.drive_changed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d response words outstanding.",
                  cycle_count, awaited_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      req_word_type               w;
      logic [FIELD_POS_WIDTH-1:0] goal;
      logic [FIELD_POS_WIDTH-1:0] new_min;
      int                         off;
      int                         t;
      bit                         sender_gaps;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      error_count   = 0;
      cycle_count   = 0;
      edge_count    = 0;
      tick_count    = 0;
      change_count  = 0;
      setting_count = 0;
      clear_positioner();

      add_checked(edge_word(1'b0), report(DUTY_STOP, 16'd0, 16'd20, 1'b0));
      add_checked(edge_word(1'b1), report(DUTY_STOP, 16'd0, 16'd21, 1'b0));
      add_checked(tick_word(16'd21), report(DUTY_STOP, 16'd21, 16'd21, 1'b0));
      add_checked(tick_word(16'd100), report(DUTY_EXTEND, 16'd21, 16'd21, 1'b1));
      add_checked(tick_word(16'd0), report(DUTY_STOP, 16'd0, 16'd21, 1'b1));
      add_checked(tick_word(16'hFFFF), report(DUTY_EXTEND, 16'd21, 16'd21, 1'b1));
      add_word(edge_word(1'b1));
      add_word(tick_word(16'd22));
      add_word(tick_word(16'd22));
      add_word(tick_word(16'd10));
      add_word(tick_word(16'd21));
      add_setting(CSR_COUNT_MIN, 16'd0);
      add_setting(CSR_COUNT_MAX, 16'd0);
      add_word(edge_word(1'b0));
      add_word(edge_word(1'b0));
      add_setting(CSR_COUNT_MIN, 16'hFFFF);
      add_setting(CSR_COUNT_MAX, 16'hFFFF);
      add_word(edge_word(1'b1));
      add_word(edge_word(1'b1));
      add_setting(CSR_COUNT_MIN, 16'd500);
      add_setting(CSR_COUNT_MAX, 16'd100);
      add_word(edge_word(1'b1));
      add_word(edge_word(1'b0));
      add_setting(CSR_COUNT_MIN, 16'd0);
      add_setting(CSR_COUNT_MAX, 16'hFFFF);
      add_setting(CSR_DEADBAND, 16'd255);
      add_setting(CSR_SPARE, 16'hA5A5);
      add_word(tick_word(16'd0));
      add_word(tick_word(16'hFFFF));
      add_word(tick_word(16'd355));
      add_setting(CSR_DEADBAND, 16'hFF00);
      add_word(tick_word(16'd101));
      add_word(edge_word(1'b1));
      add_word(tick_word(16'd101));
      add_word(tick_word(16'd100));
      add_word(edge_word(1'b0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_setting) begin
            drain_replies();
            write_setting(directed_rows[i].csr_idx, directed_rows[i].csr_data);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_replies();
         case (p)
            0: write_limits(FIELD_POS_WIDTH'(COUNT_MIN_RESET),
                            FIELD_POS_WIDTH'(COUNT_MAX_RESET), DEADBAND_RESET);
            1: write_limits(16'd0, 16'hFFFF, 8'd0);
            2: write_limits(16'd65500, 16'hFFFF, 8'd255);
            3: write_limits(16'd0, 16'd30, 8'd255);
            4: write_limits(16'd200, 16'd100, 8'd3);
            5: write_limits(16'd0, 16'd0, 8'd8);
            default: begin
               new_min = FIELD_POS_WIDTH'($urandom_range(0, 65000));
               write_limits(new_min, FIELD_POS_WIDTH'(new_min + $urandom_range(0, 400)),
                            ($urandom_range(0, 4) == 0) ? 8'd255 :
                                                          8'($urandom_range(0, 16)));
            end
         endcase
         goal        = pos_count;
         sender_gaps = (p % 3 != 2);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (sender_gaps && $urandom_range(0, 99) < 45) idle_for(pick_gap());
            if ($urandom_range(0, 199) == 0) drain_replies();
            w.dir_level = 1'($urandom_range(0, 1));
            w.target    = FIELD_POS_WIDTH'($urandom);
            if ($urandom_range(0, 99) < 70) begin
               // The encoder mostly follows the drive, with some noise.
               w.func = FUNC_EDGE;
               if ($urandom_range(0, 99) >= 15) begin
                  if (duty_reg == DUTY_EXTEND) w.dir_level = 1'b1;
                  else if (duty_reg == DUTY_RETRACT) w.dir_level = 1'b0;
               end
            end else begin
               w.func = FUNC_TICK;
               if ($urandom_range(0, 99) < 25) begin
                  if ($urandom_range(0, 99) < 15) begin
                     goal = FIELD_POS_WIDTH'($urandom);
                  end else begin
                     off = int'($urandom_range(0, 2 * (int'(band) + 12))) - int'(band) - 12;
                     t   = int'(pos_count) + off;
                     if (t < 0) goal = '0;
                     else if (t > 65535) goal = '1;
                     else goal = t[FIELD_POS_WIDTH-1:0];
                  end
               end
               w.target = goal;
            end
            send_word(w, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d words: %0d encoder edges and %0d control ticks, %0d drive changes.",
               edge_count + tick_count, edge_count, tick_count, change_count);
      $display("Made %0d register writes over limits at zero, full scale, crossed and random.",
               setting_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ebbp_pkg.sv
hw/rtl/ebbp_in_stage.sv
hw/rtl/ebbp_core.sv
hw/rtl/ebbp_out_stage.sv
hw/rtl/encoder_bang_bang_positioner.sv
tb/testbench.sv
